// File: design/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg
// Shared types, constants and helpers for the ustar stream deframer.
// ----------------------------------------------------------------------------
package usd_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int SIZE_W      = 36;
    localparam int SUM_W       = 17;
    localparam int CHK_W       = 24;
    localparam int BYTE_W      = 8;
    localparam int DATA_W      = 48;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] NAME_POS    = POS_W'(0);
    localparam logic [POS_W-1:0] SIZE_FIRST  = POS_W'(124);
    localparam logic [POS_W-1:0] SIZE_LAST   = POS_W'(135);
    localparam logic [POS_W-1:0] CHK_FIRST   = POS_W'(148);
    localparam logic [POS_W-1:0] CHK_LAST    = POS_W'(155);
    localparam logic [POS_W-1:0] MAGIC_FIRST = POS_W'(257);
    localparam logic [POS_W-1:0] MAGIC_LAST  = POS_W'(261);

    localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h37;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_CONTENT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CONTENT,
        PH_PAD,
        PH_HALT
    } usd_phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_END,
        ST_BAD_MAGIC,
        ST_BAD_CHECKSUM
    } usd_status_t;

    typedef struct packed {
        logic              kind;
        usd_status_t       status;
        logic [SIZE_W-1:0] file_size;
        logic [BYTE_W-1:0] content_byte;
        logic              last;
    } usd_item_t;

    function automatic logic [BYTE_W-1:0] magic_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h75;
            3'd1:    c = 8'h73;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h72;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/usd_front.sv
// ----------------------------------------------------------------------------
// usd_front
// Accepts archive bytes, tracks block position and phase, parses headers
// and pushes verdict and content items into the result queue.
// ----------------------------------------------------------------------------
module usd_front
    import usd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output usd_item_t         q_item
);

    usd_phase_t        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CHK_W-1:0]  chk_reg, chk_next;
    logic              chk_open_reg, chk_open_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic              size_open_reg, size_open_next;
    logic              magic_ok_reg, magic_ok_next;
    logic              name_empty_reg, name_empty_next;
    logic [SIZE_W-1:0] left_reg, left_next;
    logic              verify_reg;

    logic              accept;
    logic              is_digit;
    logic [2:0]        digit;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  magic_off;
    usd_status_t       verdict;

    assign in_ready  = !q_full;
    assign accept    = in_valid && !q_full;
    assign is_digit  = in_byte inside {[DIGIT_LO:DIGIT_HI]};
    assign digit     = in_byte[2:0];
    assign pos_inc   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    assign magic_off = pos_reg - MAGIC_FIRST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            verify_reg <= 1'b1;
        end else if (cfg_valid) begin
            verify_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            pos_reg        <= '0;
            sum_reg        <= '0;
            chk_reg        <= '0;
            chk_open_reg   <= 1'b1;
            size_reg       <= '0;
            size_open_reg  <= 1'b1;
            magic_ok_reg   <= 1'b1;
            name_empty_reg <= 1'b0;
            left_reg       <= '0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            chk_reg        <= chk_next;
            chk_open_reg   <= chk_open_next;
            size_reg       <= size_next;
            size_open_reg  <= size_open_next;
            magic_ok_reg   <= magic_ok_next;
            name_empty_reg <= name_empty_next;
            left_reg       <= left_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        chk_next        = chk_reg;
        chk_open_next   = chk_open_reg;
        size_next       = size_reg;
        size_open_next  = size_open_reg;
        magic_ok_next   = magic_ok_reg;
        name_empty_next = name_empty_reg;
        left_next       = left_reg;
        verdict         = ST_OK;
        q_push          = 1'b0;
        q_item          = '0;

        if (accept) begin
            case (phase_reg)
                PH_CONTENT: begin
                    left_next           = left_reg - 1'b1;
                    pos_next            = pos_inc;
                    q_push              = 1'b1;
                    q_item.kind         = KIND_CONTENT;
                    q_item.content_byte = in_byte;
                    q_item.last         = (left_reg == SIZE_W'(1));
                    if (left_reg == SIZE_W'(1)) begin
                        phase_next = (pos_inc == '0) ? PH_HEADER : PH_PAD;
                    end
                end
                PH_PAD: begin
                    pos_next = pos_inc;
                    if (pos_inc == '0) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    pos_next = pos_inc;
                    if (pos_reg inside {[CHK_FIRST:CHK_LAST]}) begin
                        sum_next = sum_reg + SUM_W'(SPACE_CHAR);
                        if (chk_open_reg && is_digit) begin
                            chk_next = {chk_reg[CHK_W-4:0], digit};
                        end else begin
                            chk_open_next = 1'b0;
                        end
                    end else begin
                        sum_next = sum_reg + SUM_W'(in_byte);
                    end
                    if (pos_reg inside {[SIZE_FIRST:SIZE_LAST]}) begin
                        if (size_open_reg && is_digit) begin
                            size_next = {size_reg[SIZE_W-4:0], digit};
                        end else begin
                            size_open_next = 1'b0;
                        end
                    end
                    if (pos_reg inside {[MAGIC_FIRST:MAGIC_LAST]}) begin
                        if (in_byte != magic_char(magic_off[2:0])) begin
                            magic_ok_next = 1'b0;
                        end
                    end
                    if (pos_reg == NAME_POS) begin
                        name_empty_next = (in_byte == '0);
                    end

                    if (pos_reg == POS_LAST) begin
                        if (name_empty_reg) begin
                            verdict = ST_END;
                        end else if (!magic_ok_reg) begin
                            verdict = ST_BAD_MAGIC;
                        end else if (verify_reg &&
                                     (CHK_W'(sum_next) != chk_reg)) begin
                            verdict = ST_BAD_CHECKSUM;
                        end else begin
                            verdict = ST_OK;
                        end
                        if (verdict != ST_OK) begin
                            phase_next = PH_HALT;
                        end else if (size_reg == '0) begin
                            phase_next = PH_HEADER;
                        end else begin
                            left_next  = size_reg;
                            phase_next = PH_CONTENT;
                        end
                        q_push           = 1'b1;
                        q_item.kind      = KIND_VERDICT;
                        q_item.status    = verdict;
                        q_item.file_size = size_reg;
                        sum_next         = '0;
                        chk_next         = '0;
                        chk_open_next    = 1'b1;
                        size_next        = '0;
                        size_open_next   = 1'b1;
                        magic_ok_next    = 1'b1;
                        name_empty_next  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: design/usd_queue.sv
// ----------------------------------------------------------------------------
// usd_queue
// Short first-in first-out queue of result items between front and back.
// ----------------------------------------------------------------------------
module usd_queue
    import usd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  usd_item_t push_item,
    output logic      full,
    input  logic      pop,
    output usd_item_t pop_item,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    usd_item_t         mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/usd_back.sv
// ----------------------------------------------------------------------------
// usd_back
// Drains the result queue into the output register and packs each beat.
// ----------------------------------------------------------------------------
module usd_back
    import usd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  usd_item_t         q_item,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic      valid_reg;
    usd_item_t item_reg;

    assign q_pop    = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tuser  = item_reg.kind;
    assign m_tlast  = item_reg.last;
    assign m_tdata  = {{(DATA_W - 2 - SIZE_W - BYTE_W){1'b0}}, item_reg.content_byte,
                       item_reg.file_size, item_reg.status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
    end

endmodule

// File: design/ustar_stream_deframer_unit.sv
// ----------------------------------------------------------------------------
// ustar_stream_deframer_unit
// Splits a ustar archive byte stream into header verdicts and member content.
// ----------------------------------------------------------------------------
// One archive byte is taken per cycle with no gaps while the result queue has
// room. Header bytes are summed and parsed as they arrive; at the last byte of
// each 512-byte header one verdict beat (tuser 0) carries status and octal
// size. Content bytes follow as beats with tuser 1, tlast on the final one; pad
// bytes are dropped. After an end or error verdict all input is swallowed until
// reset. A verdict or content beat is written first into the result queue, then
// into the output register, where it is held until accepted; the queue of
// QUEUE_DEPTH entries lets input continue while the output is stalled, and
// input stalls only once the queue is full.
// ----------------------------------------------------------------------------
module ustar_stream_deframer_unit
    import usd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // archive_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // status[1:0], file_size[37:2], content_byte[45:38]
    output logic              m_tuser,   // item_kind
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    logic      q_push, q_full, q_pop, q_empty;
    usd_item_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    usd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    usd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    usd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
